// File: src/cmwc_random_generator_defines.svh
// ============================================================================
// cmwc_random_generator_defines.svh
// Assertion macros shared by the generator's modules.
// ============================================================================
`ifndef CMWC_RANDOM_GENERATOR_DEFINES_SVH
`define CMWC_RANDOM_GENERATOR_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define CMWC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define CMWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/cmwc_pkg.sv
// ============================================================================
// cmwc_pkg
// Types and constants of the complement-multiply-with-carry generator.
// ============================================================================
package cmwc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    localparam logic [31:0] GOLDEN_STEP     = 32'h9e37_79b9;
    localparam logic [14:0] MULTIPLIER      = 15'd18782;
    localparam logic [31:0] COMPLEMENT_BASE = 32'hffff_fffe;
    localparam logic [31:0] CARRY_START     = 32'd362436;

    localparam int MUL_W  = 47;
    localparam int PROD_W = 48;

    localparam int Q_DEPTH = 2;
    localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    localparam int DIV_STEPS = 32;
    localparam int DC_W      = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {
        OP_RESEED  = 2'd0,
        OP_RAW     = 2'd1,
        OP_BOUNDED = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [30:0] bound;
        logic        bad;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FILL,
        BK_READ,
        BK_MAC,
        BK_FIX,
        BK_DSTART,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage

// File: src/cmwc_random_generator.sv
// ============================================================================
// cmwc_random_generator
// Complement-multiply-with-carry generator with a 4096-word lag table.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_ready) carries one command per transaction:
//   i_op selects reseed, raw draw, bounded draw or no operation; i_bound is
//   the exclusive limit of a bounded draw. Output channel (o_valid / i_ready)
//   returns exactly one transaction per command: o_value and o_bad_bound.
//   The user writes the seed word (i_seed_wr_en / i_seed_wr_data) only while
//   the block is idle; the block does not enforce it. The next reseed uses it.
// Execution:
//   A raw draw goes from queue to output register through one table read,
//   one multiply-accumulate, and one carry fix with write-back. A bounded
//   draw adds the bit-serial remainder unit (32 steps). A reseed sweeps the
//   table one word a cycle. Commands execute one at a time.
// Reset:
//   Carry returns to 362436 and the position to the last entry. The table
//   itself is not cleared: issue a reseed before the first draw.
// Stall:
//   A result waits in the output register while a two-entry command queue
//   keeps taking transactions; the engine holds its finished result until
//   the output register frees.
// ============================================================================
module cmwc_random_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_wr_en,
    input  logic [31:0] i_seed_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [30:0] i_bound,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_value,
    output logic        o_bad_bound
);
    import cmwc_pkg::*;

    logic [31:0] r_seed_value;
    t_cmd        w_cmd;
    logic        w_cmd_valid;
    logic        w_cmd_pop;

    // Hold the seed word until the next configuration write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_value <= '0;
        end else if (i_seed_wr_en) begin
            r_seed_value <= i_seed_wr_data;
        end
    end

    // Accept and classify commands; queue them for the engine.
    cmwc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_bound     (i_bound),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_pop       (w_cmd_pop)
    );

    // Execute reseeds and draws; drive the output register.
    cmwc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cmd_valid  (w_cmd_valid),
        .o_cmd_pop    (w_cmd_pop),
        .i_seed_value (r_seed_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_value      (o_value),
        .o_bad_bound  (o_bad_bound)
    );

endmodule

// File: src/cmwc_divider.sv
// ============================================================================
// cmwc_divider
// Restoring remainder unit, one quotient bit per cycle.
// ============================================================================
`include "cmwc_random_generator_defines.svh"

module cmwc_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [30:0] i_divisor,
    output logic        o_done,
    output logic [30:0] o_remainder
);
    import cmwc_pkg::*;

    logic            r_busy;
    logic            r_done;
    logic [DC_W-1:0] r_count;
    logic [31:0]     r_quo;
    logic [30:0]     r_rem;
    logic [30:0]     r_div;
    logic [31:0]     w_trial;
    logic [30:0]     n_rem;

    // Shift in the next dividend bit and subtract when it fits.
    always_comb begin
        w_trial = {r_rem, r_quo[31]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = 31'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = w_trial[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= DC_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_count <= r_count - 1'b1;
                if (r_count == DC_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[30:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

    `CMWC_ASSERT(a_done_not_busy, !r_done || !r_busy, "divider done while busy")

endmodule

// File: src/cmwc_back.sv
// ============================================================================
// cmwc_back
// Execution engine: lag table, reseed sweep, draw step and result register.
// ============================================================================
`include "cmwc_random_generator_defines.svh"

module cmwc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cmwc_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    input  logic [31:0]    i_seed_value,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_value,
    output logic           o_bad_bound
);
    import cmwc_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic [31:0]       mem [TABLE_DEPTH];
    logic [31:0]       r_rd_data;
    t_cmd              r_cmd;
    logic [IDX_W-1:0]  r_pos;
    logic [IDX_W-1:0]  r_k;
    logic [31:0]       r_carry;
    logic [31:0]       r_t1;
    logic [31:0]       r_t2;
    logic [31:0]       r_t3;
    logic [PROD_W-1:0] r_prod;
    logic [31:0]       r_word;
    logic [31:0]       r_result;
    logic              r_out_valid;
    logic [31:0]       r_out_value;
    logic              r_out_bad;

    logic              w_mem_we;
    logic [IDX_W-1:0]  w_mem_addr;
    logic [31:0]       w_mem_data;
    logic              w_div_start;
    logic              w_out_load;
    logic [31:0]       w_fill;
    logic [MUL_W-1:0]  w_mul;
    logic [31:0]       w_hi;
    logic [31:0]       w_sum0;
    logic              w_wrap;
    logic [31:0]       w_sum;
    logic [31:0]       w_draw;
    logic [31:0]       w_mag;
    logic              w_div_done;
    logic [30:0]       w_rem;

    // Reseed recurrence: the seed, then two words stepping by the golden constant.
    always_comb begin
        if (r_k == '0) begin
            w_fill = i_seed_value;
        end else if (r_k == IDX_W'(1) || r_k == IDX_W'(2)) begin
            w_fill = r_t1 + GOLDEN_STEP;
        end else begin
            w_fill = r_t3 ^ r_t2 ^ GOLDEN_STEP ^ {{(32-IDX_W){1'b0}}, r_k};
        end
    end

    // End-around carry fix of the registered product.
    always_comb begin
        w_mul  = MULTIPLIER * r_rd_data;
        w_hi   = {{(64-PROD_W){1'b0}}, r_prod[PROD_W-1:32]};
        w_sum0 = r_prod[31:0] + w_hi;
        w_wrap = (w_sum0 < w_hi);
        w_sum  = w_sum0 + {31'b0, w_wrap};
        w_draw = COMPLEMENT_BASE - w_sum;
        w_mag  = r_word[31] ? (32'd0 - r_word) : r_word;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op) inside
                        OP_RESEED:          n_state = BK_FILL;
                        OP_RAW, OP_BOUNDED: n_state = BK_READ;
                        default:            n_state = BK_DONE;
                    endcase
                end
            end
            BK_FILL: begin
                if (r_k == LAST_IDX) begin
                    n_state = BK_DONE;
                end
            end
            BK_READ:   n_state = BK_MAC;
            BK_MAC:    n_state = BK_FIX;
            BK_FIX: begin
                if (r_cmd.op == OP_BOUNDED && !r_cmd.bad) begin
                    n_state = BK_DSTART;
                end else begin
                    n_state = BK_DONE;
                end
            end
            BK_DSTART: n_state = BK_DIV;
            BK_DIV: begin
                if (w_div_done) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (w_out_load) begin
                    n_state = BK_IDLE;
                end
            end
            default:   n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop   = (r_state == BK_IDLE) && i_cmd_valid;
        w_mem_we    = (r_state == BK_FILL) || (r_state == BK_FIX);
        w_mem_addr  = (r_state == BK_FILL) ? r_k : r_pos;
        w_mem_data  = (r_state == BK_FILL) ? w_fill : w_draw;
        w_div_start = (r_state == BK_DSTART);
        w_out_load  = (r_state == BK_DONE) && (!r_out_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_addr] <= w_mem_data;
        end
        r_rd_data <= mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_pos       <= LAST_IDX;
            r_carry     <= CARRY_START;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd_pop && (i_cmd.op == OP_RAW || i_cmd.op == OP_BOUNDED)) begin
                r_pos <= (r_pos == LAST_IDX) ? '0 : r_pos + 1'b1;
            end
            if (r_state == BK_FILL && r_k == LAST_IDX) begin
                r_pos   <= LAST_IDX;
                r_carry <= CARRY_START;
            end
            if (r_state == BK_FIX) begin
                r_carry <= w_hi + {31'b0, w_wrap};
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd    <= i_cmd;
            r_k      <= '0;
            r_result <= '0;
        end
        if (r_state == BK_FILL) begin
            r_k  <= r_k + 1'b1;
            r_t1 <= w_fill;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
        end
        if (r_state == BK_MAC) begin
            r_prod <= PROD_W'(w_mul) + PROD_W'(r_carry);
        end
        if (r_state == BK_FIX) begin
            r_word <= w_draw;
            if (r_cmd.op == OP_RAW) begin
                r_result <= w_draw;
            end
        end
        if (r_state == BK_DIV && w_div_done) begin
            r_result <= {1'b0, w_rem};
        end
        if (w_out_load) begin
            r_out_value <= r_result;
            r_out_bad   <= r_cmd.bad;
        end
    end

    cmwc_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_mag),
        .i_divisor   (r_cmd.bound),
        .o_done      (w_div_done),
        .o_remainder (w_rem)
    );

    assign o_valid     = r_out_valid;
    assign o_value     = r_out_value;
    assign o_bad_bound = r_out_bad;

    `CMWC_ASSERT(a_mem_we_state, !w_mem_we || r_state == BK_FILL || r_state == BK_FIX,
        "table written outside fill or fix")
    `CMWC_ASSERT_NEXT(a_div_follows_start, w_div_start, r_state == BK_DIV,
        "divider started outside division")

endmodule

// File: src/cmwc_front.sv
// ============================================================================
// cmwc_front
// Input acceptance, opcode classification and command queue.
// ============================================================================
`include "cmwc_random_generator_defines.svh"

module cmwc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_op,
    input  logic [30:0]    i_bound,
    output cmwc_pkg::t_cmd o_cmd,
    output logic           o_cmd_valid,
    input  logic           i_pop
);
    import cmwc_pkg::*;

    t_cmd            r_q [Q_DEPTH];
    logic [QP_W-1:0] r_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr;
    logic [QC_W-1:0] r_count;
    t_cmd            w_cmd;
    logic            w_push;

    // Flag a zero bound up front so the engine skips the remainder.
    always_comb begin
        w_cmd.op    = t_op'(i_op);
        w_cmd.bound = i_bound;
        w_cmd.bad   = (t_op'(i_op) == OP_BOUNDED) && (i_bound == '0);
    end

    assign o_ready     = (r_count != QC_W'(Q_DEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `CMWC_ASSERT(a_count_in_range, r_count <= QC_W'(Q_DEPTH), "queue count overflow")
    `CMWC_ASSERT(a_pop_nonempty, !i_pop || r_count != '0, "pop from empty queue")

endmodule

// File: tb/cmwc_random_generator_test.sv
`timescale 1ns / 1ps
// ============================================================================
// cmwc_random_generator_test
// Self-checking bench for the complement-multiply-with-carry generator: a
// table of directed commands, then phases of random commands under varying
// seeds, sender bursts and receiver stalls, scored by a model or typed rows.
// ============================================================================
module cmwc_random_generator_test;
    import cmwc_pkg::*;

    // Idle cycles (nothing accepted on either channel) before giving up.
    // The slowest gap is a reseed sweep behind a long stall.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 150;
    localparam int WRAP_PHASE     = 5;
    localparam int WRAP_ITEMS     = 150;
    localparam int PRESSURE_PHASE = 2;
    localparam int TAIL_CYCLES    = 64;
    localparam int N_DIRECTED     = 18;

    typedef struct packed {
        logic [31:0] value;
        logic        bad_bound;
    } t_draw_result;

    // One directed command; typed marks a row whose result is given inline.
    typedef struct packed {
        t_op         op;
        logic [30:0] bound;
        logic        typed;
        logic [31:0] value;
        logic        bad_bound;
    } t_stim_row;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_RUNS
    } t_rx_mode;

    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{OP_RESEED,  31'h0000_0000, 1'b1, 32'h0, 1'b0},
        '{OP_RAW,     31'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_RAW,     31'h7fff_ffff, 1'b0, 32'h0, 1'b0},
        '{OP_BOUNDED, 31'h0000_0000, 1'b1, 32'h0, 1'b1},
        '{OP_BOUNDED, 31'h0000_0001, 1'b1, 32'h0, 1'b0},
        '{OP_BOUNDED, 31'h7fff_ffff, 1'b0, 32'h0, 1'b0},
        '{OP_BOUNDED, 31'h0000_0002, 1'b0, 32'h0, 1'b0},
        '{OP_BOUNDED, 31'h0000_0003, 1'b0, 32'h0, 1'b0},
        '{OP_NOP,     31'h7fff_ffff, 1'b1, 32'h0, 1'b0},
        '{OP_NOP,     31'h0000_0000, 1'b1, 32'h0, 1'b0},
        '{OP_BOUNDED, 31'h5555_5555, 1'b0, 32'h0, 1'b0},
        '{OP_BOUNDED, 31'h2aaa_aaaa, 1'b0, 32'h0, 1'b0},
        '{OP_BOUNDED, 31'h4000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_RESEED,  31'h7fff_ffff, 1'b1, 32'h0, 1'b0},
        '{OP_RAW,     31'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_BOUNDED, 31'h0000_0000, 1'b1, 32'h0, 1'b1},
        '{OP_BOUNDED, 31'h0000_0010, 1'b0, 32'h0, 1'b0},
        '{OP_RAW,     31'h0000_0000, 1'b0, 32'h0, 1'b0}
    };

    // DUT ports; every input holds a known value from time zero.
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_seed_wr_en   = 1'b0;
    logic [31:0] i_seed_wr_data = '0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic [1:0]  i_op           = '0;
    logic [30:0] i_bound        = '0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [31:0] o_value;
    logic        o_bad_bound;

    // Generator model state.
    logic [31:0]      model_table [TABLE_DEPTH];
    logic [31:0]      model_carry = CARRY_START;
    logic [IDX_W-1:0] model_pos   = LAST_IDX;
    logic [31:0]      model_seed  = '0;

    t_draw_result pending_draws[$];

    // Stimulus controls; rx_mode and long_hold_pending feed the receiver process.
    t_rx_mode rx_mode           = RX_RANDOM;
    bit       long_hold_pending = 1'b0;
    bit       sender_gaps       = 1'b1;

    int error_count   = 0;
    int n_reseed      = 0;
    int n_raw         = 0;
    int n_bounded     = 0;
    int n_nop         = 0;
    int n_zero_bound  = 0;
    int n_wraps       = 0;
    int n_min_word    = 0;
    int n_results     = 0;
    int n_seed_writes = 0;

    cmwc_random_generator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_wr_en   (i_seed_wr_en),
        .i_seed_wr_data (i_seed_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_bound        (i_bound),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_value        (o_value),
        .o_bad_bound    (o_bad_bound)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // Fill the lag table from the seed by the golden-ratio XOR recurrence.
    function automatic void refill_table();
        model_table[0] = model_seed;
        model_table[1] = model_seed + GOLDEN_STEP;
        model_table[2] = model_seed + GOLDEN_STEP + GOLDEN_STEP;
        for (int k = 3; k < TABLE_DEPTH; k++) begin
            model_table[k] = model_table[k-3] ^ model_table[k-2] ^ GOLDEN_STEP ^ 32'(k);
        end
        model_carry = CARRY_START;
        model_pos   = LAST_IDX;
    endfunction

    // Step the generator once: multiply-with-carry, end-around fix, store.
    function automatic logic [31:0] advance_word();
        logic [63:0] prod;
        logic [31:0] sum;
        if (model_pos == LAST_IDX) begin
            model_pos = '0;
            n_wraps++;
        end else begin
            model_pos = model_pos + 1'b1;
        end
        prod        = 64'(MULTIPLIER) * 64'(model_table[model_pos]) + 64'(model_carry);
        model_carry = prod[63:32];
        sum         = prod[31:0] + model_carry;
        if (sum < model_carry) begin
            sum         = sum + 1'b1;
            model_carry = model_carry + 1'b1;
        end
        model_table[model_pos] = COMPLEMENT_BASE - sum;
        return model_table[model_pos];
    endfunction

    function automatic t_draw_result predict_draw(input t_op op, input logic [30:0] bound);
        t_draw_result res;
        logic [31:0]  word;
        logic [31:0]  mag;
        res = '0;
        case (op)
            OP_RESEED: begin
                refill_table();
            end
            OP_RAW: begin
                res.value = advance_word();
            end
            OP_BOUNDED: begin
                word = advance_word();
                // Magnitude of the word as a signed number; the most negative
                // word gives 2^31 taken unsigned.
                mag = word[31] ? (32'd0 - word) : word;
                if (word == 32'h8000_0000) n_min_word++;
                if (bound == '0) begin
                    res.bad_bound = 1'b1;
                end else begin
                    res.value = mag % {1'b0, bound};
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_op pick_op(input bit allow_reseed);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (allow_reseed && roll < 2) return OP_RESEED;
        if (roll < 10) return OP_NOP;
        if (roll < 50) return OP_RAW;
        return OP_BOUNDED;
    endfunction

    // Mix of zero, tiny, power-of-two, near-maximum and full-range bounds.
    function automatic logic [30:0] pick_bound();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return '0;
        if (roll < 30) return 31'($urandom_range(1, 16));
        if (roll < 45) return 31'(1) << $urandom_range(0, 30);
        if (roll < 55) return 31'h7fff_ffff - 31'($urandom_range(0, 3));
        return 31'($urandom);
    endfunction

    // Offer one command and hold it until accepted, then log its expectation.
    task automatic issue_command(input t_op op, input logic [30:0] bound,
                                 input logic typed, input t_draw_result typed_result);
        t_draw_result predicted;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_op    <= op;
        i_bound <= bound;
        do @(posedge i_clk); while (!o_ready);
        predicted = predict_draw(op, bound);
        pending_draws.push_back(typed ? typed_result : predicted);
        case (op)
            OP_RESEED:  n_reseed++;
            OP_RAW:     n_raw++;
            OP_BOUNDED: n_bounded++;
            default:    n_nop++;
        endcase
        if (op == OP_BOUNDED && bound == '0) n_zero_bound++;
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Drop valid and hold until every outstanding result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_draws.size() != 0) @(negedge i_clk);
    endtask

    // Write the seed register; only called with nothing in flight.
    task automatic write_seed(input logic [31:0] seed);
        @(negedge i_clk);
        i_seed_wr_en   <= 1'b1;
        i_seed_wr_data <= seed;
        @(negedge i_clk);
        i_seed_wr_en   <= 1'b0;
        model_seed = seed;
        n_seed_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall pattern per phase plus an on-demand long hold-off
    // ------------------------------------------------------------------------
    int hold_left = 0;
    int run_left  = 0;
    bit run_on    = 1'b1;

    always @(negedge i_clk) begin
        if (hold_left == 0 && long_hold_pending) begin
            hold_left         = LONG_HOLD;
            long_hold_pending = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_ready <= 1'b1;
                RX_RANDOM: i_ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if (run_left == 0) begin
                        run_on   = !run_on;
                        run_left = run_on ? $urandom_range(1, 12) : $urandom_range(1, 8);
                    end
                    run_left--;
                    i_ready <= run_on;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each transaction with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin : check_result
            t_draw_result oldest;
            if (pending_draws.size() == 0) begin
                $error("unexpected result: value %h, bad_bound %b", o_value, o_bad_bound);
                error_count++;
            end else begin
                oldest = pending_draws.pop_front();
                n_results++;
                if (o_value !== oldest.value) begin
                    $error("value: expected %h, actual %h", oldest.value, o_value);
                    error_count++;
                end
                if (o_bad_bound !== oldest.bad_bound) begin
                    $error("bad_bound: expected %b, actual %b", oldest.bad_bound, o_bad_bound);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles with no transaction on either channel
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("** cmwc_random_generator: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        t_draw_result typed_result;
        int           burst_left;
        int           n_items;
        logic [31:0]  seed;

        // Hold reset, then release it on a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: starts with a reseed so no draw ever reads an
        // unwritten table entry.
        write_seed(32'hffff_ffff);
        rx_mode = RX_RANDOM;
        for (int r = 0; r < N_DIRECTED; r++) begin
            typed_result.value     = DIRECTED_ROWS[r].value;
            typed_result.bad_bound = DIRECTED_ROWS[r].bad_bound;
            issue_command(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].bound,
                          DIRECTED_ROWS[r].typed, typed_result);
        end
        drain_results();

        // Random phases. Each opens with a reseed under a fresh seed; the
        // sender pauses between phases until every result has come back.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 0)      seed = 32'h0000_0000;
            else if (ph == 1) seed = 32'hffff_ffff;
            else              seed = $urandom;
            write_seed(seed);

            rx_mode     = t_rx_mode'(ph % 3);
            sender_gaps = (ph != 0 && ph != PRESSURE_PHASE);
            if (ph == PRESSURE_PHASE) begin
                rx_mode = RX_ALWAYS;
            end
            // The no-reseed phase draws from a single fill of the table.
            n_items    = (ph == WRAP_PHASE) ? WRAP_ITEMS : PHASE_ITEMS;
            burst_left = 0;

            issue_command(OP_RESEED, pick_bound(), 1'b0, '0);
            if (ph == PRESSURE_PHASE) begin
                // Let the sweep finish, then hold the receiver off while the
                // sender keeps offering draws, so the queue fills and the
                // input stalls.
                drain_results();
                long_hold_pending = 1'b1;
            end
            for (int i = 1; i < n_items; i++) begin
                if (sender_gaps) begin
                    if (burst_left == 0) begin
                        pause_sender($urandom_range(1, 12));
                        burst_left = $urandom_range(1, 16);
                    end
                    burst_left--;
                end
                issue_command(pick_op(ph != WRAP_PHASE), pick_bound(), 1'b0, '0);
            end
            drain_results();
        end

        // Catch any stray result after the last expectation.
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Coverage: %0d commands (%0d reseed, %0d raw, %0d bounded, %0d no-op), %0d results",
                 n_reseed + n_raw + n_bounded + n_nop, n_reseed, n_raw, n_bounded, n_nop,
                 n_results);
        $display("Coverage: %0d seed writes, %0d zero bounds, %0d table wraps, %0d min words",
                 n_seed_writes, n_zero_bound, n_wraps, n_min_word);
        if (error_count == 0 && pending_draws.size() == 0) begin
            $display("** cmwc_random_generator: PASSED **");
        end else begin
            $display("** cmwc_random_generator: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/cmwc_pkg.sv
src/cmwc_divider.sv
src/cmwc_back.sv
src/cmwc_front.sv
src/cmwc_random_generator.sv
tb/cmwc_random_generator_test.sv
